// ----- rtl/core/csrpt_pkg.sv -----
// Shared types and constants for the credit-scaled relay pulse timer.
package csrpt_pkg;

   localparam int NUM_SLOTS    = 4;
   localparam int CHANNELS_DEF = 4;
   localparam int CHAN_W       = 2;
   localparam int REQ_CHAN_W   = 4;
   localparam int BASE_W       = 24;
   localparam int CREDIT_W     = 16;
   localparam int PRICE_W      = 16;
   localparam int PROD_W       = CREDIT_W + BASE_W;
   localparam int DUR_W        = 32;
   localparam int STATUS_W     = 4;
   localparam int RELAY_W      = 4;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 2;
   localparam int PRICE_RESET  = 1;
   localparam int STATUS_RESET = 0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRICE_CH1   = 3'd0,
      CSR_PRICE_CH2   = 3'd1,
      CSR_PRICE_CH3   = 3'd2,
      CSR_PRICE_CH4   = 3'd3,
      CSR_STATUS_MASK = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_START,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      logic                  req_type;
      logic [REQ_CHAN_W-1:0] channel;
      logic [BASE_W-1:0]     base_ms;
      logic [CREDIT_W-1:0]   credit;
   } req_item_type;

   typedef struct packed {
      logic [RELAY_W-1:0]  relay_bits;
      logic [STATUS_W-1:0] status_bits;
      logic [DUR_W-1:0]    duration_ms;
      logic                credit_clear;
      logic [RELAY_W-1:0]  expired_bits;
   } rsp_item_type;

   // classified job handed from the front end to the timer bank
   typedef struct packed {
      op_type              op;
      logic [CHAN_W-1:0]   chan;
      logic [PROD_W-1:0]   product;
      logic [PRICE_W-1:0]  price;
   } job_type;

endpackage

// ----- rtl/core/csrpt_front.sv -----
// Front end: classifies requests, picks the price and forms credit * base.
module csrpt_front #(
   parameter int CHANNELS = csrpt_pkg::CHANNELS_DEF
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  csrpt_pkg::req_item_type       req_data,
   input  logic [csrpt_pkg::PRICE_W-1:0] price [csrpt_pkg::NUM_SLOTS],
   input  logic                          q_full,
   output logic                          q_push,
   output csrpt_pkg::job_type            q_job
);

   logic                          chan_ok;
   logic [csrpt_pkg::CHAN_W-1:0]  chan_idx;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign chan_ok  = (req_data.channel != '0) && (int'(req_data.channel) <= CHANNELS);
   assign chan_idx = csrpt_pkg::CHAN_W'(req_data.channel - 4'd1);

   always_comb begin
      if (!req_data.req_type) begin
         q_job.op = csrpt_pkg::OP_TICK;
      end else if (chan_ok) begin
         q_job.op = csrpt_pkg::OP_START;
      end else begin
         q_job.op = csrpt_pkg::OP_IGNORE;
      end
      q_job.chan    = chan_idx;
      q_job.product = csrpt_pkg::PROD_W'(req_data.credit) * csrpt_pkg::PROD_W'(req_data.base_ms);
      q_job.price   = price[chan_idx];
   end

endmodule

// ----- rtl/core/csrpt_queue.sv -----
// Two-entry job queue between the front end and the timer bank.
module csrpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csrpt_pkg::job_type push_job,
   input  logic               pop,
   output csrpt_pkg::job_type head_job,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = $clog2(csrpt_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(csrpt_pkg::QUEUE_DEPTH + 1);

   csrpt_pkg::job_type entry_ff [csrpt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(csrpt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(csrpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(csrpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/csrpt_div.sv -----
// Restoring divider, one quotient bit per cycle.
module csrpt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [csrpt_pkg::PROD_W-1:0]  dividend,
   input  logic [csrpt_pkg::PRICE_W-1:0] divisor,
   output logic                          done,
   output logic [csrpt_pkg::PROD_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(csrpt_pkg::PROD_W + 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [csrpt_pkg::PRICE_W-1:0]  div_ff, div_in;
   logic [csrpt_pkg::PRICE_W-1:0]  rem_ff, rem_in;
   logic [csrpt_pkg::PROD_W-1:0]   quot_ff, quot_in;
   logic [csrpt_pkg::PRICE_W:0]    rem_sh;

   assign done     = done_ff;
   assign quotient = quot_ff;

   // partial remainder shifted left with the next dividend bit
   assign rem_sh = {rem_ff, quot_ff[csrpt_pkg::PROD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(csrpt_pkg::PROD_W);
         div_in  = divisor;
         rem_in  = '0;
         quot_in = dividend;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in  = csrpt_pkg::PRICE_W'(rem_sh - {1'b0, div_ff});
            quot_in = {quot_ff[csrpt_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[csrpt_pkg::PRICE_W-1:0];
            quot_in = {quot_ff[csrpt_pkg::PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

endmodule

// ----- rtl/core/csrpt_back.sv -----
// Back end: timer bank, millisecond count and result register.
module csrpt_back #(
   parameter int CHANNELS = csrpt_pkg::CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  csrpt_pkg::job_type             q_job,
   output logic                           q_pop,
   input  logic [csrpt_pkg::STATUS_W-1:0] status_mask,
   output logic                           div_start,
   input  logic                           div_done,
   input  logic [csrpt_pkg::PROD_W-1:0]   div_quot,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output csrpt_pkg::rsp_item_type        rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_COMMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [csrpt_pkg::DUR_W-1:0]      now_ff, now_in;
   logic [csrpt_pkg::DUR_W-1:0]      start_ff [CHANNELS];
   logic [csrpt_pkg::DUR_W-1:0]      start_in [CHANNELS];
   logic [csrpt_pkg::DUR_W-1:0]      target_ff [CHANNELS];
   logic [csrpt_pkg::DUR_W-1:0]      target_in [CHANNELS];
   logic [CHANNELS-1:0]              active_ff, active_in;
   logic [csrpt_pkg::CHAN_W-1:0]     chan_ff, chan_in;
   logic [csrpt_pkg::DUR_W-1:0]      dur_ff, dur_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   csrpt_pkg::rsp_item_type          rsp_data_ff, rsp_data_in;
   logic                             out_free;
   logic [csrpt_pkg::RELAY_W-1:0]    relay_vec;
   logic [csrpt_pkg::RELAY_W-1:0]    expired_vec;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      active_in    = active_ff;
      chan_in      = chan_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      expired_vec  = '0;
      relay_vec    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               unique case (q_job.op)
                  csrpt_pkg::OP_TICK: begin
                     now_in = now_ff + 1'b1;
                     for (int i = 0; i < CHANNELS; i++) begin
                        if (active_ff[i] && ((now_in - start_ff[i]) >= target_ff[i])) begin
                           active_in[i]   = 1'b0;
                           expired_vec[i] = 1'b1;
                        end
                     end
                     for (int i = 0; i < CHANNELS; i++) begin
                        relay_vec[i] = active_in[i];
                     end
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.relay_bits   = relay_vec;
                     rsp_data_in.status_bits  = status_mask;
                     rsp_data_in.duration_ms  = '0;
                     rsp_data_in.credit_clear = 1'b0;
                     rsp_data_in.expired_bits = expired_vec;
                  end
                  csrpt_pkg::OP_START: begin
                     chan_in = q_job.chan;
                     if (q_job.price == '0) begin
                        dur_in   = '1;
                        state_in = ST_COMMIT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        relay_vec[i] = active_ff[i];
                     end
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.relay_bits   = relay_vec;
                     rsp_data_in.status_bits  = status_mask;
                     rsp_data_in.duration_ms  = '0;
                     rsp_data_in.credit_clear = 1'b0;
                     rsp_data_in.expired_bits = '0;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               // quotient beyond 32 bits saturates
               if (div_quot[csrpt_pkg::PROD_W-1:csrpt_pkg::DUR_W] != '0) begin
                  dur_in = '1;
               end else begin
                  dur_in = div_quot[csrpt_pkg::DUR_W-1:0];
               end
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (chan_ff == csrpt_pkg::CHAN_W'(i)) begin
                     active_in[i] = 1'b1;
                     start_in[i]  = now_ff;
                     target_in[i] = dur_ff;
                  end
               end
               for (int i = 0; i < CHANNELS; i++) begin
                  relay_vec[i] = active_in[i];
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.relay_bits   = relay_vec;
               rsp_data_in.status_bits  = status_mask;
               rsp_data_in.duration_ms  = dur_ff;
               rsp_data_in.credit_clear = 1'b1;
               rsp_data_in.expired_bits = '0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            start_ff[i]  <= '0;
            target_ff[i] <= '0;
         end
         active_ff    <= '0;
         chan_ff      <= '0;
         dur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         active_ff    <= active_in;
         chan_ff      <= chan_in;
         dur_ff       <= dur_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule

// ----- rtl/core/credit_scaled_relay_pulse_timer_core.sv -----
// Path: a tick or ignored start passes through the job queue and the result register; a
// start also runs the 40-step serial divider unless its price is zero, then commits.
// Throughput: one tick per cycle while results are taken and no start holds the timer bank.
// A two-entry job queue lets requests be taken while the timer bank is busy.
// Reset (synchronous): count, timers and relays cleared, prices to 1, status mask to 0,
// queue emptied; no clearing pass, ready as soon as reset drops.
module credit_scaled_relay_pulse_timer_core #(
   parameter int CHANNELS = csrpt_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  csrpt_pkg::req_item_type         req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output csrpt_pkg::rsp_item_type         rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [csrpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csrpt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [csrpt_pkg::PRICE_W-1:0]  price_ff [csrpt_pkg::NUM_SLOTS];
   logic [csrpt_pkg::STATUS_W-1:0] status_ff;
   logic                           q_full;
   logic                           q_empty;
   logic                           q_push;
   logic                           q_pop;
   csrpt_pkg::job_type             push_job;
   csrpt_pkg::job_type             head_job;
   logic                           div_start;
   logic                           div_done;
   logic [csrpt_pkg::PROD_W-1:0]   div_quot;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < csrpt_pkg::NUM_SLOTS; i++) begin
            price_ff[i] <= csrpt_pkg::PRICE_W'(csrpt_pkg::PRICE_RESET);
         end
         status_ff <= csrpt_pkg::STATUS_W'(csrpt_pkg::STATUS_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            csrpt_pkg::CSR_PRICE_CH1:   price_ff[0] <= csr_wdata[csrpt_pkg::PRICE_W-1:0];
            csrpt_pkg::CSR_PRICE_CH2:   price_ff[1] <= csr_wdata[csrpt_pkg::PRICE_W-1:0];
            csrpt_pkg::CSR_PRICE_CH3:   price_ff[2] <= csr_wdata[csrpt_pkg::PRICE_W-1:0];
            csrpt_pkg::CSR_PRICE_CH4:   price_ff[3] <= csr_wdata[csrpt_pkg::PRICE_W-1:0];
            csrpt_pkg::CSR_STATUS_MASK: status_ff   <= csr_wdata[csrpt_pkg::STATUS_W-1:0];
            default: ;
         endcase
      end
   end

   csrpt_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .price     (price_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   csrpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   csrpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head_job.product),
      .divisor  (head_job.price),
      .done     (div_done),
      .quotient (div_quot)
   );

   csrpt_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .status_mask (status_ff),
      .div_start   (div_start),
      .div_done    (div_done),
      .div_quot    (div_quot),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a channel reported expired is off in the same result
   a_expired_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.relay_bits & rsp_data.expired_bits) == '0))
      else $error("expired channel still shown active");

   // starts never report expirations
   a_start_no_expire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.credit_clear) |-> (rsp_data.expired_bits == '0))
      else $error("start result carries expired bits");

   // a nonzero duration only comes with a consumed credit
   a_dur_with_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.credit_clear) |-> (rsp_data.duration_ms == '0))
      else $error("duration reported without credit clear");

   // the divider is only launched when a start job is popped
   a_div_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (q_pop && (head_job.op == csrpt_pkg::OP_START)))
      else $error("divider launched without a start job");

endmodule
